// ----- rtl/core/rrs_pkg.sv -----
// Package of types, constants and codes shared by the rated record sorter.
package rrs_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ID_W     = 16;
  localparam int RATING_W = 16;
  localparam int PAGE_W   = 8;
  localparam int PSIZE_W  = 5;
  localparam int PROD_W   = PSIZE_W + PAGE_W;

  localparam logic [PSIZE_W-1:0] PSIZE_RESET = 5'd10;
  localparam logic [PSIZE_W-1:0] PSIZE_MIN   = 5'd1;
  localparam logic [PSIZE_W-1:0] PSIZE_MAX   = 5'd16;

  typedef enum logic [1:0] {
    MODE_INSERT  = 2'd0,
    MODE_REQUEST = 2'd1,
    MODE_CLEAR   = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [RATING_W-1:0] rating;
  } rec_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept_ins;
    logic accept_req;
    logic clear;
    logic ins_read;
    logic ins_shift;
    logic ins_place;
    logic emit_read;
    logic emit_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic n_zero;
    logic at_top;
    logic lower;
    logic rem_last;
    logic out_free;
  } stat_t;

endpackage

// ----- rtl/core/rrs_ctrl.sv -----
// Controller state machine of the rated record sorter.
module rrs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [1:0]     mode,
  input  rrs_pkg::stat_t stat,
  output logic           in_ready,
  output rrs_pkg::cmd_t  cmd
);
  import rrs_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (mode)
            MODE_INSERT:  if (!stat.full) state_next = ST_INS_RD;
            MODE_REQUEST: if (!stat.n_zero) state_next = ST_EMIT_RD;
            default:      state_next = ST_IDLE;
          endcase
        end
      end
      ST_INS_RD:  state_next = stat.at_top ? ST_IDLE : ST_INS_CMP;
      ST_INS_CMP: state_next = stat.lower ? ST_INS_RD : ST_IDLE;
      ST_EMIT_RD: state_next = ST_EMIT_LD;
      ST_EMIT_LD: begin
        if (stat.out_free) state_next = stat.rem_last ? ST_IDLE : ST_EMIT_RD;
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (mode)
            MODE_INSERT:  cmd.accept_ins = !stat.full;
            MODE_REQUEST: cmd.accept_req = 1'b1;
            MODE_CLEAR:   cmd.clear = 1'b1;
            default:      cmd = '0;
          endcase
        end
      end
      ST_INS_RD: begin
        cmd.ins_place = stat.at_top;
        cmd.ins_read  = !stat.at_top;
      end
      ST_INS_CMP: begin
        cmd.ins_shift = stat.lower;
        cmd.ins_place = !stat.lower;
      end
      ST_EMIT_RD: cmd.emit_read = 1'b1;
      ST_EMIT_LD: cmd.emit_load = stat.out_free;
      default:    cmd = '0;
    endcase
  end

endmodule

// ----- rtl/core/rrs_datapath.sv -----
// Datapath of the rated record sorter: store, counters, page math, output register.
module rrs_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  rrs_pkg::cmd_t                    cmd,
  output rrs_pkg::stat_t                   stat,
  input  logic [rrs_pkg::ID_W-1:0]         place_id,
  input  logic [rrs_pkg::RATING_W-1:0]     rating,
  input  logic [rrs_pkg::PAGE_W-1:0]       page,
  input  logic                             cfg_valid,
  input  logic [rrs_pkg::PSIZE_W-1:0]      cfg_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rrs_pkg::ID_W-1:0]         out_place_id,
  output logic [rrs_pkg::RATING_W-1:0]     out_rating,
  output logic                             last
);
  import rrs_pkg::*;

  rec_t mem [CAPACITY];
  rec_t rdata;
  rec_t ins_rec;

  logic [ADDR_W-1:0]  cursor;
  logic [ADDR_W-1:0]  addr;
  logic [CNT_W-1:0]   rem;
  logic [CNT_W-1:0]   count;
  logic [PSIZE_W-1:0] page_size;

  logic [PSIZE_W-1:0] s_eff;
  logic [PROD_W-1:0]  prod_full;
  logic [PROD_W-1:0]  prod_prev;
  logic [CNT_W-1:0]   n_emit;
  logic [ADDR_W-1:0]  start;

  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  rec_t              mem_wdata;

  // Page size clamp and page window.
  always_comb begin
    s_eff = page_size;
    if (page_size == '0) begin
      s_eff = PSIZE_MIN;
    end else if (page_size > PSIZE_MAX) begin
      s_eff = PSIZE_MAX;
    end
    prod_full = PROD_W'(s_eff) * PROD_W'(page);
    prod_prev = PROD_W'(s_eff) * PROD_W'(page - PAGE_W'(1));
    if (page != '0 && prod_full <= PROD_W'(count)) begin
      n_emit = CNT_W'(s_eff);
      start  = ADDR_W'(prod_prev);
    end else if (page == PAGE_W'(1)) begin
      n_emit = count;
      start  = '0;
    end else begin
      n_emit = '0;
      start  = '0;
    end
  end

  assign mem_we    = cmd.ins_shift | cmd.ins_place;
  assign mem_waddr = cursor;
  assign mem_wdata = cmd.ins_shift ? rdata : ins_rec;
  assign mem_re    = cmd.ins_read | cmd.emit_read;
  assign mem_raddr = cmd.emit_read ? addr : cursor - ADDR_W'(1);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_ins) begin
      ins_rec.id     <= place_id;
      ins_rec.rating <= rating;
      cursor         <= ADDR_W'(count);
    end else if (cmd.ins_shift) begin
      cursor <= cursor - ADDR_W'(1);
    end
    if (cmd.accept_req) begin
      addr <= start;
    end else if (cmd.emit_load) begin
      addr <= addr + ADDR_W'(1);
    end
    if (cmd.emit_load) begin
      out_place_id <= rdata.id;
      out_rating   <= rdata.rating;
      last         <= (rem == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rem       <= '0;
      page_size <= PSIZE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        count <= '0;
      end else if (cmd.ins_place) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.accept_req) begin
        rem <= n_emit;
      end else if (cmd.emit_load) begin
        rem <= rem - CNT_W'(1);
      end
      if (cfg_valid) page_size <= cfg_data;
      if (cmd.emit_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.full     = (count == CNT_W'(CAPACITY));
    stat.n_zero   = (n_emit == '0);
    stat.at_top   = (cursor == '0);
    stat.lower    = (rdata.rating < ins_rec.rating);
    stat.rem_last = (rem == CNT_W'(1));
    stat.out_free = !out_valid || out_ready;
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("record count above capacity");

  a_place_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_place |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the count by one");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_load |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  a_emit_remaining: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_read |-> rem != '0)
    else $error("read issued with no record left to emit");

  a_no_full_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.accept_ins |-> count < CNT_W'(CAPACITY))
    else $error("insert started into a full store");
`endif

endmodule

// ----- rtl/core/rated_record_sorter_top_page.sv -----
// Top level of the rated record sorter with paged read-out.
//
//   channel | signals                                         | direction
//   --------+-------------------------------------------------+----------
//   in      | in_valid, in_ready, mode, place_id, rating, page | into block
//   out     | out_valid, out_ready, out_place_id, out_rating,  | out of block
//           | last                                            |
//   cfg     | cfg_valid, cfg_ready, cfg_data (page_size)      | into block
//
// Clear, an ignored mode and a dropped insert into a full store are handled in ST_IDLE.
// An insert walks up from the bottom of the store: each record rated lower than
// the new one is moved one rank down by a read (ST_INS_RD) and then a write
// (ST_INS_CMP) to the store, and the new record is placed where the walk stops.
// A page request reads each emitted record (ST_EMIT_RD) and loads it into the
// output register (ST_EMIT_LD); a stalled output holds the read-out in place.
// Reset empties the store (count zero) and sets page_size to 10; store
// contents are not cleared, only ranks below the count are ever read.
module rated_record_sorter_top_page (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       mode,
  input  logic [rrs_pkg::ID_W-1:0]         place_id,
  input  logic [rrs_pkg::RATING_W-1:0]     rating,
  input  logic [rrs_pkg::PAGE_W-1:0]       page,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rrs_pkg::ID_W-1:0]         out_place_id,
  output logic [rrs_pkg::RATING_W-1:0]     out_rating,
  output logic                             last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rrs_pkg::PSIZE_W-1:0]      cfg_data
);
  import rrs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Take configuration writes at any time; the page size is sampled only
  // when a request transaction is accepted.
  assign cfg_ready = 1'b1;

  // Sequence each transaction: decode, shift-insert loop, page read-out.
  rrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // Hold the sorted store, counts, page window and the output register.
  rrs_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .place_id     (place_id),
    .rating       (rating),
    .page         (page),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_place_id (out_place_id),
    .out_rating   (out_rating),
    .last         (last)
  );

endmodule

// ----- verif/testbench.sv -----
// Testbench of the rated record sorter: ranked-store predictor, random traffic, paged checks.
import rrs_pkg::*;

typedef struct packed {
  logic [ID_W-1:0]     id;
  logic [RATING_W-1:0] rating;
  logic                is_last;
} page_row_t;

class ranked_page_board;
  rec_t               ranked[$];
  page_row_t          expected_rows[$];
  logic [PSIZE_W-1:0] page_size;
  int                 failures;

  function new();
    page_size = PSIZE_RESET;
    failures  = 0;
  endfunction

  function void set_page_size(logic [PSIZE_W-1:0] v);
    page_size = v;
  endfunction

  // Zero reads as one, anything past the maximum as the maximum.
  function int unsigned rows_per_page();
    int unsigned s;
    s = page_size;
    if (s == 0) s = 1;
    if (s > PSIZE_MAX) s = PSIZE_MAX;
    return s;
  endfunction

  function int pending();
    return expected_rows.size();
  endfunction

  function int count();
    return ranked.size();
  endfunction

  function void queue_rows(int unsigned first, int unsigned n);
    page_row_t row;
    for (int unsigned k = 0; k < n; k++) begin
      row.id      = ranked[first + k].id;
      row.rating  = ranked[first + k].rating;
      row.is_last = (k + 1 == n);
      expected_rows.push_back(row);
    end
  endfunction

  function void note_item(logic [1:0] m, logic [ID_W-1:0] id, logic [RATING_W-1:0] r,
                          logic [PAGE_W-1:0] p);
    int unsigned pos;
    int unsigned s;
    int unsigned pg;
    rec_t        rec;
    s  = rows_per_page();
    pg = p;
    case (m)
      MODE_INSERT: begin
        // Drop the record when the store is full.
        if (ranked.size() < CAPACITY) begin
          pos = 0;
          while (pos < ranked.size() && ranked[pos].rating >= r) pos++;
          rec.id     = id;
          rec.rating = r;
          ranked.insert(pos, rec);
        end
      end
      MODE_REQUEST: begin
        if (pg != 0 && s * pg <= ranked.size()) queue_rows((pg - 1) * s, s);
        else if (pg == 1) queue_rows(0, ranked.size());
      end
      MODE_CLEAR: ranked.delete();
      default: ;
    endcase
  endfunction

  function void check_row(logic [ID_W-1:0] id, logic [RATING_W-1:0] r, logic l);
    page_row_t want;
    if (expected_rows.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("unexpected row: id %h rating %h last %b", id, r, l);
      return;
    end
    want = expected_rows.pop_front();
    if (want.id !== id || want.rating !== r || want.is_last !== l) begin
      failures++;
      if (failures <= 10)
        $display("row mismatch: expected id %h rating %h last %b, got id %h rating %h last %b",
                 want.id, want.rating, want.is_last, id, r, l);
    end
  endfunction
endclass

module testbench;
  // An insert may move every record once; give it room.
  localparam int SETTLE_CYCLES = 2 * CAPACITY + 8;
  localparam int LIMIT_TIME    = 1_000_000;
  // Mode code the block has to ignore.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic [1:0]          mode         = MODE_INSERT;
  logic [ID_W-1:0]     place_id     = '0;
  logic [RATING_W-1:0] rating       = '0;
  logic [PAGE_W-1:0]   page         = '0;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic [ID_W-1:0]     out_place_id;
  logic [RATING_W-1:0] out_rating;
  logic                last;
  logic                cfg_valid    = 1'b0;
  logic                cfg_ready;
  logic [PSIZE_W-1:0]  cfg_data     = PSIZE_RESET;

  // Idling switches, flipped per phase; the closing phase runs with both off.
  bit send_gaps   = 1'b1;
  bit sink_stalls = 1'b1;
  int stall_left  = 0;

  ranked_page_board board = new();

  rated_record_sorter_top_page dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .place_id     (place_id),
    .rating       (rating),
    .page         (page),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_place_id (out_place_id),
    .out_rating   (out_rating),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #LIMIT_TIME;
    $display("TB_ERROR");
    $finish;
  end

  // Output side: stall in random bursts, change only on the falling edge.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Sample every completed output transaction on the rising edge.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_row(out_place_id, out_rating, last);
  end

  // Drive one input transaction and hold it until accepted. A random gap drops
  // valid first; otherwise valid stays high straight into the next item.
  task automatic send_item(input logic [1:0] m, input logic [ID_W-1:0] id,
                           input logic [RATING_W-1:0] r, input logic [PAGE_W-1:0] p);
    int gap;
    gap = 0;
    if (send_gaps && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 5);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    place_id <= id;
    rating   <= r;
    page     <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_item(m, id, r, p);
  endtask

  task automatic write_page_size(input logic [PSIZE_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_page_size(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, wait for every pending row, then give a silent insert time to finish.
  task automatic drain_and_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mix tie-heavy ratings, the extremes and fully random ones.
  function automatic logic [RATING_W-1:0] rand_rating();
    case ($urandom_range(0, 3))
      0:       return RATING_W'($urandom_range(1, 3)) << 8;
      1:       return ($urandom_range(0, 1) != 0) ? '1 : '0;
      default: return RATING_W'($urandom);
    endcase
  endfunction

  // Mostly pages that exist or sit just past the end, some zero or wild ones.
  function automatic logic [PAGE_W-1:0] pick_page();
    int unsigned span;
    int unsigned roll;
    span = board.count() / board.rows_per_page();
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll < 3) return PAGE_W'($urandom_range(0, 255));
    return PAGE_W'($urandom_range(1, span + 1));
  endfunction

  task automatic run_phase(input int n_items, input bit fill_first);
    int done;
    int roll;
    done = 0;
    // Fill past capacity so the tail inserts get dropped.
    if (fill_first) begin
      send_item(MODE_CLEAR, ID_W'($urandom), RATING_W'($urandom), PAGE_W'($urandom));
      done++;
      repeat (CAPACITY + 6) begin
        send_item(MODE_INSERT, ID_W'($urandom), rand_rating(), PAGE_W'($urandom));
        done++;
      end
    end
    while (done < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        send_item(MODE_CLEAR, ID_W'($urandom), RATING_W'($urandom), PAGE_W'($urandom));
        done++;
      end else if (roll < 6) begin
        // Ignored by the block, so it does not count.
        send_item(MODE_UNUSED, ID_W'($urandom), RATING_W'($urandom), PAGE_W'($urandom));
      end else if (roll < 55) begin
        send_item(MODE_INSERT, ID_W'($urandom), rand_rating(), PAGE_W'($urandom));
        done++;
      end else begin
        send_item(MODE_REQUEST, ID_W'($urandom), RATING_W'($urandom), pick_page());
        done++;
      end
    end
  endtask

  initial begin
    logic [PSIZE_W-1:0] sizes[7];

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset page size of ten.
    send_item(MODE_REQUEST, '0, '0, 8'd1);          // empty store, first page
    send_item(MODE_REQUEST, '0, '0, 8'd0);          // page zero
    send_item(MODE_INSERT, 16'hFFFF, 16'hFFFF, '0);
    send_item(MODE_INSERT, 16'h0000, 16'h0000, '1);
    send_item(MODE_INSERT, 16'h1234, 16'hFFFF, '0); // tie with the top record
    send_item(MODE_INSERT, 16'h00AA, 16'h8000, '0);
    send_item(MODE_INSERT, 16'h5555, 16'h8000, '0); // tie in the middle
    send_item(MODE_UNUSED, '1, '1, '1);
    send_item(MODE_REQUEST, '0, '0, 8'd1);          // short store: whole list
    send_item(MODE_REQUEST, '0, '0, 8'd2);
    send_item(MODE_REQUEST, '1, '1, 8'd255);
    send_item(MODE_INSERT, 16'hAAAA, 16'h0000, '0); // tie at the bottom
    send_item(MODE_INSERT, 16'h0F0F, 16'h0001, '0);
    send_item(MODE_INSERT, 16'hF0F0, 16'hFFFE, '0);
    send_item(MODE_INSERT, 16'h8001, 16'h7FFF, '0);
    send_item(MODE_INSERT, 16'h7FFE, 16'h8001, '0);
    send_item(MODE_INSERT, 16'h0001, 16'h0100, '0);
    send_item(MODE_REQUEST, '0, '0, 8'd1);          // full first page of ten
    send_item(MODE_REQUEST, '0, '0, 8'd2);          // second page is incomplete: no rows
    send_item(MODE_CLEAR, '0, '0, '0);
    send_item(MODE_REQUEST, '0, '0, 8'd1);
    drain_and_idle();

    // Random phases, each under its own page size; the extremes come first.
    sizes[0] = PSIZE_MIN;
    sizes[1] = PSIZE_MAX;
    sizes[2] = 5'd0;
    sizes[3] = '1;
    sizes[4] = PSIZE_W'($urandom_range(2, 15));
    sizes[5] = PSIZE_W'($urandom_range(17, 30));
    sizes[6] = PSIZE_RESET;
    for (int i = 0; i < 7; i++) begin
      send_gaps   = (i != 6) && ($urandom_range(0, 3) != 0);
      sink_stalls = (i != 6) && ($urandom_range(0, 3) != 0);
      write_page_size(sizes[i]);
      run_phase((i == 1) ? 100 : 58, i == 1);
      drain_and_idle();
    end

    if (board.failures == 0 && board.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
